// ----- hdl/cpts_pkg.sv -----
// Shared types and constants of the credit priority task scheduler.
// No dependencies; imported by cpts_best and the top level.
`default_nettype none
package cpts_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned CREDIT_W = 8;
  localparam int unsigned SLEEP_W  = 16;
  localparam int unsigned OUT_IDX_W = 3;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_SCHEDULE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SLEEP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADD      = 2'd2;

  // Control of the shared best-candidate compare unit
  typedef struct packed {
    logic clear;  // forget the current candidate
    logic load;   // offer one table entry to the compare
  } best_ctrl_t;

endpackage : cpts_pkg
`default_nettype wire

// ----- hdl/cpts_best.sv -----
// Shared compare unit: tracks the awake entry with the most credit over a scan.
// Depends on cpts_pkg.
`default_nettype none
module cpts_best import cpts_pkg::*; #(
  parameter int unsigned IdxW = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire best_ctrl_t          ctrl_i,
  input  wire logic [IdxW-1:0]     idx_i,
  input  wire logic [CREDIT_W-1:0] credit_i,
  input  wire logic                awake_i,
  output logic                     found_o,
  output logic [IdxW-1:0]          best_idx_o,
  output logic [CREDIT_W-1:0]      best_credit_o
);

  logic                found_q;
  logic [IdxW-1:0]     best_idx_q;
  logic [CREDIT_W-1:0] best_credit_q;
  logic                take;

  // Strictly greater keeps the earliest entry on a tie
  assign take = ctrl_i.load && awake_i && (!found_q || (credit_i > best_credit_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctrl_i.clear) begin
      best_idx_q    <= idx_i;
      best_credit_q <= credit_i;
    end
  end

  assign found_o       = found_q;
  assign best_idx_o    = best_idx_q;
  assign best_credit_o = best_credit_q;

endmodule : cpts_best
`default_nettype wire

// ----- hdl/credit_priority_task_scheduler.sv -----
// Top level of the credit priority task scheduler: sequencer and task table.
// Depends on cpts_pkg and cpts_best.
`default_nettype none
// A command is taken on a rising edge with start high and busy low; every
// command gives exactly one result, shown for one cycle with done_o high,
// and the receiver cannot hold it off. Add and sleep commands complete at
// the edge of acceptance and their result appears in the following cycle;
// busy does not rise for them. A schedule command walks the task table with
// one shared compare unit, reading one entry a cycle from the table memories
// (registered reads). A walk runs a best-credit scan, then, if the winner
// has no credit left, a refill pass and a second scan, a credit decrement
// (skipped when no task is awake), and a sleep-ageing pass. The result is
// strobed in the cycle in which busy falls, when the next command may
// already be given. Table entries are only ever read below the task
// count, so the table needs no clearing after reset.
module credit_priority_task_scheduler import cpts_pkg::*; #(
  parameter int unsigned MAX_TASKS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [KIND_W-1:0]    kind_i,
  input  wire logic [PRIO_W-1:0]    priority_req_i,
  input  wire logic [SLEEP_W-1:0]   sleep_ticks_i,
  output logic                      done_o,
  output logic [OUT_IDX_W-1:0]      task_index_o,
  output logic                      idle_o,
  output logic                      rejected_o
);

  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_REFILL = 3'd2;
  localparam logic [2:0] ST_DEC    = 3'd3;
  localparam logic [2:0] ST_AGE    = 3'd4;

  // Sequencer state
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] addr_q, addr_d;
  logic          rd_vld_q, rd_vld_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic          refilled_q, refilled_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] running_q, running_d;

  // Result registers
  logic                 done_q, done_d;
  logic [OUT_IDX_W-1:0] res_idx_q, res_idx_d;
  logic                 res_idle_q, res_idle_d;
  logic                 res_rej_q, res_rej_d;

  // Task table
  logic [PRIO_W-1:0]   prio_mem   [MAX_TASKS];
  logic [CREDIT_W-1:0] credit_mem [MAX_TASKS];
  logic [SLEEP_W-1:0]  sleep_mem  [MAX_TASKS];
  logic [PRIO_W-1:0]   prio_rd_q;
  logic [CREDIT_W-1:0] credit_rd_q;
  logic [SLEEP_W-1:0]  sleep_rd_q;
  logic [IW-1:0]       rd_addr;

  logic                prio_we, credit_we, sleep_we;
  logic [IW-1:0]       prio_wa, credit_wa, sleep_wa;
  logic [PRIO_W-1:0]   prio_wd;
  logic [CREDIT_W-1:0] credit_wd;
  logic [SLEEP_W-1:0]  sleep_wd;

  // Compare unit
  best_ctrl_t          best_ctrl;
  logic                best_found;
  logic [IW-1:0]       best_idx;
  logic [CREDIT_W-1:0] best_credit;

  logic          accept;
  logic          in_pass;
  logic          issue;
  logic          pass_end;
  logic [IW+2:0] best_ext;
  logic [CW+2:0] slot_ext;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign rd_addr  = addr_q[IW-1:0];
  assign in_pass  = (state_q == ST_SCAN) || (state_q == ST_REFILL) || (state_q == ST_AGE);
  assign issue    = in_pass && (addr_q < count_q);
  assign pass_end = in_pass && (addr_q >= count_q) && !rd_vld_q;

  // Slot numbers reported masked to the 3-bit result field
  assign best_ext = {3'b000, best_idx};
  assign slot_ext = {3'b000, count_q};

  cpts_best #(
    .IdxW (IW)
  ) u_best (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (best_ctrl),
    .idx_i         (rd_idx_q),
    .credit_i      (credit_rd_q),
    .awake_i       (sleep_rd_q == '0),
    .found_o       (best_found),
    .best_idx_o    (best_idx),
    .best_credit_o (best_credit)
  );

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    refilled_d = refilled_q;
    count_d    = count_q;
    running_d  = running_q;
    done_d     = 1'b0;
    res_idx_d  = res_idx_q;
    res_idle_d = res_idle_q;
    res_rej_d  = res_rej_q;
    prio_we    = 1'b0;
    prio_wa    = count_q[IW-1:0];
    prio_wd    = priority_req_i;
    credit_we  = 1'b0;
    credit_wa  = count_q[IW-1:0];
    credit_wd  = priority_req_i;
    sleep_we   = 1'b0;
    sleep_wa   = count_q[IW-1:0];
    sleep_wd   = '0;
    best_ctrl  = '0;

    // Advance the table walk one entry a cycle
    if (issue) begin
      rd_vld_d = 1'b1;
      rd_idx_d = addr_q[IW-1:0];
      addr_d   = addr_q + CW'(1);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_idx_d  = '0;
          res_idle_d = 1'b0;
          res_rej_d  = 1'b0;
          unique case (kind_i)
            KIND_SCHEDULE: begin
              state_d         = ST_SCAN;
              addr_d          = '0;
              refilled_d      = 1'b0;
              best_ctrl.clear = 1'b1;
            end
            KIND_SLEEP: begin
              done_d = 1'b1;
              if (running_q < count_q) begin
                sleep_we = 1'b1;
                sleep_wa = running_q[IW-1:0];
                sleep_wd = sleep_ticks_i;
              end
            end
            KIND_ADD: begin
              done_d = 1'b1;
              if (count_q >= CW'(MAX_TASKS)) begin
                res_rej_d = 1'b1;
              end else begin
                prio_we   = 1'b1;
                credit_we = 1'b1;
                sleep_we  = 1'b1;
                count_d   = count_q + CW'(1);
                res_idx_d = slot_ext[OUT_IDX_W-1:0];
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        best_ctrl.load = rd_vld_q;
        if (pass_end) begin
          addr_d = '0;
          priority if (!best_found) begin
            // Nothing awake: report idle, still age the sleepers
            running_d  = CW'(MAX_TASKS);
            res_idle_d = 1'b1;
            state_d    = ST_AGE;
          end else if ((best_credit == '0) && !refilled_q) begin
            refilled_d = 1'b1;
            state_d    = ST_REFILL;
          end else begin
            state_d = ST_DEC;
          end
        end
      end
      ST_REFILL: begin
        if (rd_vld_q) begin
          credit_we = 1'b1;
          credit_wa = rd_idx_q;
          credit_wd = prio_rd_q;
        end
        if (pass_end) begin
          addr_d          = '0;
          best_ctrl.clear = 1'b1;
          state_d         = ST_SCAN;
        end
      end
      ST_DEC: begin
        // Take one credit from the winner, saturating at zero
        credit_we = 1'b1;
        credit_wa = best_idx;
        credit_wd = (best_credit != '0) ? (best_credit - CREDIT_W'(1)) : best_credit;
        running_d = CW'(best_idx);
        res_idx_d = best_ext[OUT_IDX_W-1:0];
        addr_d    = '0;
        state_d   = ST_AGE;
      end
      ST_AGE: begin
        if (rd_vld_q && (sleep_rd_q != '0)) begin
          sleep_we = 1'b1;
          sleep_wa = rd_idx_q;
          sleep_wd = sleep_rd_q - SLEEP_W'(1);
        end
        if (pass_end) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      refilled_q <= 1'b0;
      count_q    <= '0;
      running_q  <= CW'(MAX_TASKS);
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      addr_q     <= addr_d;
      rd_vld_q   <= rd_vld_d;
      refilled_q <= refilled_d;
      count_q    <= count_d;
      running_q  <= running_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    res_idx_q  <= res_idx_d;
    res_idle_q <= res_idle_d;
    res_rej_q  <= res_rej_d;
  end

  // Table memories: one write and one registered read each per cycle
  always_ff @(posedge clk_i) begin
    if (prio_we) begin
      prio_mem[prio_wa] <= prio_wd;
    end
    prio_rd_q <= prio_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (credit_we) begin
      credit_mem[credit_wa] <= credit_wd;
    end
    credit_rd_q <= credit_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sleep_we) begin
      sleep_mem[sleep_wa] <= sleep_wd;
    end
    sleep_rd_q <= sleep_mem[rd_addr];
  end

  assign done_o       = done_q;
  assign task_index_o = res_idx_q;
  assign idle_o       = res_idle_q;
  assign rejected_o   = res_rej_q;

  // The task count never passes the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_TASKS))
    else $error("task count beyond table size");

  // A result transfer is only strobed while the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobed during a schedule walk");

  // An accepted schedule command keeps the block busy in the next cycle
  a_sched_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KIND_SCHEDULE)) |=> busy)
    else $error("schedule command did not start a walk");

  // The decrement step only runs with a winner in hand
  a_dec_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEC) |-> best_found)
    else $error("decrement without a chosen task");

  // An idle answer carries no slot and no rejection
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_idle_q) |-> ((res_idx_q == '0) && !res_rej_q))
    else $error("idle result with stray fields");

endmodule : credit_priority_task_scheduler
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench of credit_priority_task_scheduler: a task table model predicts each
// result, and a scoreboard compares every strobed result in order.
// Depends on cpts_pkg and the RTL of the scheduler only.
`default_nettype none
module tb;
  import cpts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_TASKS = 8;
  localparam int unsigned NO_TASK   = MAX_TASKS;  // running slot when nothing was chosen
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] idx;
    logic                 idle;
    logic                 rej;
  } sched_result_t;

  // Task table model: own copy of the table, results queued in transfer order.
  class task_table_model;
    logic [PRIO_W-1:0]   prio_q   [MAX_TASKS];
    logic [CREDIT_W-1:0] credit_q [MAX_TASKS];
    logic [SLEEP_W-1:0]  sleep_q  [MAX_TASKS];
    int unsigned n_tasks;
    int unsigned running;
    sched_result_t pending_results[$];
    int unsigned n_errors, n_checked;
    int unsigned n_sched, n_idle, n_refill, n_sleep, n_add, n_reject, n_unused;

    function new();
      foreach (prio_q[i]) begin
        prio_q[i] = '0;
        credit_q[i] = '0;
        sleep_q[i] = '0;
      end
      n_tasks = 0;
      running = NO_TASK;
    endfunction

    // Awake task with most credit, earliest slot on a tie; NO_TASK if none.
    function int unsigned best_awake();
      int unsigned best;
      best = NO_TASK;
      for (int unsigned i = 0; i < n_tasks; i++) begin
        if (sleep_q[i] != 0) continue;
        if (best == NO_TASK || credit_q[i] > credit_q[best]) best = i;
      end
      return best;
    endfunction

    function void accept_cmd(logic [KIND_W-1:0] kind, logic [PRIO_W-1:0] prio,
                             logic [SLEEP_W-1:0] ticks);
      sched_result_t r;
      int unsigned pick;
      r = '0;
      case (kind)
        KIND_SCHEDULE: begin
          n_sched++;
          pick = best_awake();
          if (pick == NO_TASK) begin
            running = NO_TASK;
            r.idle = 1'b1;
            n_idle++;
          end else begin
            // Winner out of credit: refill the whole table and pick again
            if (credit_q[pick] == 0) begin
              for (int unsigned i = 0; i < n_tasks; i++) credit_q[i] = prio_q[i];
              pick = best_awake();
              n_refill++;
            end
            if (credit_q[pick] != 0) credit_q[pick] = credit_q[pick] - 1'b1;
            running = pick;
            r.idx = pick[OUT_IDX_W-1:0];
          end
          for (int unsigned i = 0; i < n_tasks; i++)
            if (sleep_q[i] != 0) sleep_q[i] = sleep_q[i] - 1'b1;
        end
        KIND_SLEEP: begin
          n_sleep++;
          if (running < n_tasks) sleep_q[running] = ticks;
        end
        KIND_ADD: begin
          n_add++;
          if (n_tasks >= MAX_TASKS) begin
            r.rej = 1'b1;
            n_reject++;
          end else begin
            prio_q[n_tasks] = prio;
            credit_q[n_tasks] = prio;
            sleep_q[n_tasks] = '0;
            r.idx = n_tasks[OUT_IDX_W-1:0];
            n_tasks++;
          end
        end
        default: n_unused++;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: task_index %0d idle %0b rejected %0b",
                 $time, got.idx, got.idle, got.rej);
        n_errors++;
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      if (got.idx !== want.idx) begin
        $display("%0t: task_index expected %0d actual %0d", $time, want.idx, got.idx);
        n_errors++;
      end
      if (got.idle !== want.idle) begin
        $display("%0t: idle expected %0b actual %0b", $time, want.idle, got.idle);
        n_errors++;
      end
      if (got.rej !== want.rej) begin
        $display("%0t: rejected expected %0b actual %0b", $time, want.rej, got.rej);
        n_errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [KIND_W-1:0]    kind_i;
  logic [PRIO_W-1:0]    priority_req_i;
  logic [SLEEP_W-1:0]   sleep_ticks_i;
  logic                 done_o;
  logic [OUT_IDX_W-1:0] task_index_o;
  logic                 idle_o;
  logic                 rejected_o;

  task_table_model model = new();

  credit_priority_task_scheduler #(
    .MAX_TASKS(MAX_TASKS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .priority_req_i(priority_req_i),
    .sleep_ticks_i (sleep_ticks_i),
    .done_o        (done_o),
    .task_index_o  (task_index_o),
    .idle_o        (idle_o),
    .rejected_o    (rejected_o)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Take each strobed result at the rising edge that ends its cycle; the
  // receiver has no way to stall, so every strobe is a transfer.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) model.check_result({task_index_o, idle_o, rejected_o});
  end

  // Present one command from the falling edge, idling the sender first with
  // the given chance per cycle, and hold it until an edge sees busy low.
  task automatic send_cmd(logic [KIND_W-1:0] kind, logic [PRIO_W-1:0] prio,
                          logic [SLEEP_W-1:0] ticks, int unsigned gap_pct);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    kind_i = kind;
    priority_req_i = prio;
    sleep_ticks_i = ticks;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    model.accept_cmd(kind, prio, ticks);
  endtask

  // Drop start and hold off until every expected result has been taken.
  task automatic drain_results();
    @(negedge clk_i);
    start = 1'b0;
    while (model.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random traffic on a full table: mostly ticks and short sleeps, with a few
  // long sleeps, rejected adds and unused kinds mixed in.
  task automatic run_random(int unsigned count, int unsigned gap_pct);
    int unsigned roll;
    logic [PRIO_W-1:0]  prio;
    logic [SLEEP_W-1:0] ticks;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      prio = PRIO_W'($urandom_range(255));
      ticks = ($urandom_range(99) < 3) ? SLEEP_W'($urandom_range(65535))
                                       : SLEEP_W'($urandom_range(12));
      if (roll < 58)      send_cmd(KIND_SCHEDULE, prio, ticks, gap_pct);
      else if (roll < 83) send_cmd(KIND_SLEEP, prio, ticks, gap_pct);
      else if (roll < 94) send_cmd(KIND_ADD, prio, ticks, gap_pct);
      else                send_cmd(KIND_UNUSED, prio, ticks, gap_pct);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    kind_i = '0;
    priority_req_i = '0;
    sleep_ticks_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: empty table, sleeping while idle, the unused kind,
    // zero-priority refill, all tasks asleep, ties, and a full table.
    send_cmd(KIND_SCHEDULE, 8'h00, 16'h0000, 0);  // empty table gives idle
    send_cmd(KIND_SLEEP,    8'h00, 16'hFFFF, 0);  // nothing running: no effect
    send_cmd(KIND_UNUSED,   8'hFF, 16'hFFFF, 0);
    send_cmd(KIND_ADD,      8'h00, 16'h0000, 0);  // slot 0, priority 0
    send_cmd(KIND_SCHEDULE, 8'h00, 16'h0000, 0);  // zero credit: refill, still 0
    send_cmd(KIND_SLEEP,    8'h00, 16'h0002, 0);
    send_cmd(KIND_SCHEDULE, 8'h00, 16'h0000, 0);  // everything asleep: idle
    send_cmd(KIND_SLEEP,    8'h00, 16'h0007, 0);  // idle again: no effect
    send_cmd(KIND_SCHEDULE, 8'h00, 16'h0000, 0);
    send_cmd(KIND_ADD,      8'hFF, 16'h0000, 0);
    send_cmd(KIND_ADD,      8'hFF, 16'h0000, 0);
    send_cmd(KIND_SCHEDULE, 8'h00, 16'h0000, 0);  // tie on 255: earliest wins
    send_cmd(KIND_SLEEP,    8'h00, 16'hFFFF, 0);  // park the big tasks for the run
    send_cmd(KIND_SCHEDULE, 8'h00, 16'h0000, 0);
    send_cmd(KIND_SLEEP,    8'h00, 16'hFFFE, 0);
    send_cmd(KIND_ADD,      8'h01, 16'h0000, 0);
    send_cmd(KIND_ADD,      8'h02, 16'h0000, 0);
    send_cmd(KIND_ADD,      8'h03, 16'h0000, 0);
    send_cmd(KIND_ADD,      8'h04, 16'h0000, 0);
    send_cmd(KIND_ADD,      8'h06, 16'h0000, 0);
    send_cmd(KIND_ADD,      8'hAA, 16'h5555, 0);  // table full: rejected
    send_cmd(KIND_SCHEDULE, 8'h00, 16'h0000, 0);
    send_cmd(KIND_SLEEP,    8'h00, 16'h0000, 0);
    send_cmd(KIND_SCHEDULE, 8'h00, 16'h0000, 0);
    drain_results();

    // Random part in three phases of sender idling, with a full drain between
    run_random(245, 38);
    drain_results();
    run_random(245, 56);
    drain_results();
    run_random(245, 0);
    drain_results();
    repeat (50) @(posedge clk_i);

    $display("Covered %0d transfers, %0d results checked: %0d ticks (%0d idle, %0d refills),",
             model.n_sched + model.n_sleep + model.n_add + model.n_unused, model.n_checked,
             model.n_sched, model.n_idle, model.n_refill);
    $display("  %0d sleeps, %0d adds (%0d rejected), %0d unused kinds",
             model.n_sleep, model.n_add, model.n_reject, model.n_unused);
    if (model.n_errors == 0 && model.pending_results.size() == 0) begin
      $display("credit_priority_task_scheduler: match");
    end else begin
      $display("credit_priority_task_scheduler: mismatch");
    end
    $finish;
  end

  // Bound the run: the slowest correct run is well under a millisecond
  initial begin
    #5ms;
    $display("credit_priority_task_scheduler: mismatch");
    $finish;
  end

endmodule : tb
`default_nettype wire
